// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the equalizer sequencer; they use the clk and rst_n of the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sspeq_pkg.sv -----
// Shared types, register codes and the microcode program of the shelf and peak equalizer.
package sspeq_pkg;

  // Fixed widths of the filter state and of the output level register.
  localparam int STATE_BITS   = 32;
  localparam int LEVEL_BITS   = 12;
  localparam int LEVEL_FRAC   = 9;
  localparam int REG_IDX_BITS = 3;

  // Configuration register indexes.
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
  localparam reg_idx_t REG_LOW_SHELF  = 3'd0;
  localparam reg_idx_t REG_HIGH_SHELF = 3'd1;
  localparam reg_idx_t REG_BAND1_LOOP = 3'd2;
  localparam reg_idx_t REG_BAND1_TAPS = 3'd3;
  localparam reg_idx_t REG_BAND2_LOOP = 3'd4;
  localparam reg_idx_t REG_BAND2_TAPS = 3'd5;
  localparam reg_idx_t REG_LEVEL      = 3'd6;

  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 12'd512;

  // Multiplier coefficient operand.
  typedef enum logic [3:0] {
    A_SH_B0, A_SH_B1, A_SH_A1, A_F, A_Q, A_F1, A_TD, A_TC, A_LEVEL
  } a_sel_t;

  // Multiplier data operand.
  typedef enum logic [2:0] {
    B_XIN, B_INH, B_OUTH, B_BP, B_HIGH, B_NBP
  } b_sel_t;

  // Accumulator action on the registered product.
  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  // Round, add and saturate step and where its result goes.
  typedef enum logic [2:0] {
    FIN_NONE, FIN_SHELF, FIN_LOW, FIN_HIGH, FIN_NBP, FIN_BAND, FIN_LEVEL
  } fin_op_t;

  // Sequencing of the step counter.
  typedef enum logic [1:0] {
    J_NEXT, J_FLAT, J_STAGE, J_CHAN
  } jmp_t;

  typedef logic [4:0] pc_t;

  // Entry points of the program.
  localparam pc_t PC_SHELF     = 5'd0;
  localparam pc_t PC_BAND      = 5'd5;
  localparam pc_t PC_BAND_LOOP = 5'd15;
  localparam pc_t PC_LAST      = 5'd18;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    fin_op_t fin_op;
    jmp_t    jmp;
    pc_t     target;
  } uword_t;

  localparam uword_t UW_NOP = '{A_SH_B0, B_XIN, ACC_HOLD, FIN_NONE, J_NEXT, PC_SHELF};

  // Control from the sequencer to the datapath.
  typedef struct packed {
    uword_t uw;
    logic   stg;
    logic   ch;
    logic   start;
    logic   emit;
  } seq_ctl_t;

  typedef enum logic {
    SQ_IDLE, SQ_RUN
  } sq_state_t;

  // Program for one channel. A selected product goes into the product register, and the
  // accumulator takes it from that register in the step after the selection.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w = UW_NOP;
    case (pc)
      // Shelf: b0*x + b1*x1 + a1*y1, run for low then high shelf.
      5'd0:  w = '{A_SH_B0, B_XIN,  ACC_HOLD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd1:  w = '{A_SH_B1, B_INH,  ACC_LOAD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd2:  w = '{A_SH_A1, B_OUTH, ACC_ADD,  FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd3:  w = '{A_SH_B0, B_XIN,  ACC_ADD,  FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd4:  w = '{A_SH_B0, B_XIN,  ACC_HOLD, FIN_SHELF, J_STAGE, PC_SHELF};
      // Peaking band; a band with both taps zero is skipped.
      5'd5:  w = '{A_F1,    B_BP,   ACC_HOLD, FIN_NONE,  J_FLAT,  PC_BAND_LOOP};
      5'd6:  w = '{A_Q,     B_BP,   ACC_LOAD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd7:  w = '{A_Q,     B_BP,   ACC_LOAD, FIN_LOW,   J_NEXT,  PC_SHELF};
      5'd8:  w = '{A_F,     B_HIGH, ACC_HOLD, FIN_HIGH,  J_NEXT,  PC_SHELF};
      5'd9:  w = '{A_F,     B_HIGH, ACC_HOLD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd10: w = '{A_TD,    B_BP,   ACC_LOAD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd11: w = '{A_TD,    B_BP,   ACC_LOAD, FIN_NBP,   J_NEXT,  PC_SHELF};
      5'd12: w = '{A_TC,    B_NBP,  ACC_HOLD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd13: w = '{A_TC,    B_NBP,  ACC_ADD,  FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd14: w = '{A_TC,    B_NBP,  ACC_HOLD, FIN_BAND,  J_NEXT,  PC_SHELF};
      5'd15: w = '{A_F1,    B_BP,   ACC_HOLD, FIN_NONE,  J_STAGE, PC_BAND};
      // Output level, then the second channel or the end of the frame.
      5'd16: w = '{A_LEVEL, B_XIN,  ACC_HOLD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd17: w = '{A_LEVEL, B_XIN,  ACC_LOAD, FIN_NONE,  J_NEXT,  PC_SHELF};
      5'd18: w = '{A_LEVEL, B_XIN,  ACC_HOLD, FIN_LEVEL, J_CHAN,  PC_SHELF};
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/sspeq_cfg.sv -----
// Configuration register file of the equalizer with band state clear requests.
module sspeq_cfg #(
  parameter int COEF_BITS = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sspeq_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [3*COEF_BITS-1:0]               cfg_wdata,
  output logic [3*COEF_BITS-1:0]               shelf_coefs [2],
  output logic [3*COEF_BITS-1:0]               band_loop [2],
  output logic [2*COEF_BITS-1:0]               band_taps [2],
  output logic [sspeq_pkg::LEVEL_BITS-1:0]     level,
  output logic [1:0]                           band_clr,
  output logic [1:0]                           flat
);
  import sspeq_pkg::*;

  localparam int CW = COEF_BITS;
  // Shelf reset: b0 = 1.0, b1 = a1 = 0.
  localparam logic [3*CW-1:0] SHELF_RESET = {{(2*CW+3){1'b0}}, 1'b1, {(CW-4){1'b0}}};

  logic [3*CW-1:0]       shelf_r [2];
  logic [3*CW-1:0]       loop_r [2];
  logic [2*CW-1:0]       taps_r [2];
  logic [LEVEL_BITS-1:0] level_r;
  logic                  wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Register writes; bits above a register's width are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shelf_r <= '{SHELF_RESET, SHELF_RESET};
      loop_r  <= '{default: '0};
      taps_r  <= '{default: '0};
      level_r <= LEVEL_RESET;
    end else if (wr) begin
      case (cfg_index)
        REG_LOW_SHELF:  shelf_r[0] <= cfg_wdata;
        REG_HIGH_SHELF: shelf_r[1] <= cfg_wdata;
        REG_BAND1_LOOP: loop_r[0]  <= cfg_wdata;
        REG_BAND1_TAPS: taps_r[0]  <= cfg_wdata[2*CW-1:0];
        REG_BAND2_LOOP: loop_r[1]  <= cfg_wdata;
        REG_BAND2_TAPS: taps_r[1]  <= cfg_wdata[2*CW-1:0];
        REG_LEVEL:      level_r    <= cfg_wdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A write to either register of a band clears that band's state.
  always_comb begin
    band_clr = 2'b00;
    if (wr) begin
      case (cfg_index)
        REG_BAND1_LOOP, REG_BAND1_TAPS: band_clr = 2'b01;
        REG_BAND2_LOOP, REG_BAND2_TAPS: band_clr = 2'b10;
        default:                        band_clr = 2'b00;
      endcase
    end
  end

  assign shelf_coefs = shelf_r;
  assign band_loop   = loop_r;
  assign band_taps   = taps_r;
  assign level       = level_r;
  assign flat        = {taps_r[1] == '0, taps_r[0] == '0};

endmodule

// ----- rtl/core/sspeq_seq.sv -----
// Microcode sequencer: step counter, stage and channel bits, and the frame handshake.
`include "assert_macros.svh"

module sspeq_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          flat,
  output sspeq_pkg::seq_ctl_t ctl
);
  import sspeq_pkg::*;

  sq_state_t state_r, state_nxt;
  pc_t       pc_r, pc_nxt;
  logic      stg_r, stg_nxt;
  logic      ch_r, ch_nxt;
  logic      out_valid_r, out_valid_nxt;
  uword_t    uw;
  logic      start;
  logic      emit;
  logic      out_free;

  assign uw       = ucode_rom(pc_r);
  assign out_free = !out_valid_r || out_ready;

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = (state_r == SQ_IDLE);
    start     = in_valid && in_ready;
    emit      = (state_r == SQ_RUN) && (uw.jmp == J_CHAN) && ch_r && out_free;
    out_valid = out_valid_r;
    ctl.uw    = (state_r == SQ_RUN) ? uw : UW_NOP;
    ctl.stg   = stg_r;
    ctl.ch    = ch_r;
    ctl.start = start;
    ctl.emit  = emit;
  end

  // Next step, stage, channel and state.
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    stg_nxt       = stg_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_RUN;
          pc_nxt    = PC_SHELF;
          stg_nxt   = 1'b0;
          ch_nxt    = 1'b0;
        end
      end
      SQ_RUN: begin
        case (uw.jmp)
          J_NEXT: pc_nxt = pc_r + 1'b1;
          J_FLAT: pc_nxt = flat[stg_r] ? uw.target : pc_r + 1'b1;
          J_STAGE: begin
            if (!stg_r) begin
              stg_nxt = 1'b1;
              pc_nxt  = uw.target;
            end else begin
              stg_nxt = 1'b0;
              pc_nxt  = pc_r + 1'b1;
            end
          end
          J_CHAN: begin
            if (!ch_r) begin
              ch_nxt = 1'b1;
              pc_nxt = uw.target;
            end else if (out_free) begin
              state_nxt     = SQ_IDLE;
              out_valid_nxt = 1'b1;
              ch_nxt        = 1'b0;
            end
          end
          default: pc_nxt = pc_r + 1'b1;
        endcase
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      pc_r        <= PC_SHELF;
      stg_r       <= 1'b0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      stg_r       <= stg_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPL(a_pc_in_program, state_r == SQ_RUN, pc_r <= PC_LAST, "step counter left the program")
  `ASSERT_NEXT(a_start_at_top, start, state_r == SQ_RUN && pc_r == PC_SHELF && !ch_r && !stg_r, "frame did not start at the first step")
  `ASSERT_IMPL(a_no_overwrite, out_valid_r && !out_ready, !emit, "result written over a waiting result")
  `ASSERT_NEXT(a_emit_shows, emit, out_valid_r, "finished frame not presented")

endmodule

// ----- rtl/core/sspeq_dpath.sv -----
// Datapath: shared multiplier, accumulator, round and saturate unit, filter state.
module sspeq_dpath #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sspeq_pkg::seq_ctl_t              ctl,
  input  logic                             in_restart,
  input  logic signed [SAMPLE_BITS-1:0]    in_left,
  input  logic signed [SAMPLE_BITS-1:0]    in_right,
  input  logic [3*COEF_BITS-1:0]           shelf_coefs [2],
  input  logic [3*COEF_BITS-1:0]           band_loop [2],
  input  logic [2*COEF_BITS-1:0]           band_taps [2],
  input  logic [sspeq_pkg::LEVEL_BITS-1:0] level,
  input  logic [1:0]                       band_clr,
  output logic signed [SAMPLE_BITS-1:0]    out_left,
  output logic signed [SAMPLE_BITS-1:0]    out_right
);
  import sspeq_pkg::*;

  localparam int CW   = COEF_BITS;
  localparam int AW   = CW + 1;
  localparam int PW   = AW + STATE_BITS;
  localparam int ACW  = PW + 2;
  localparam int SW   = ACW + 2;
  localparam int FRAC = CW - 4;

  localparam logic signed [ACW-1:0] HALF_C =
    {{(ACW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [ACW-1:0] HALF_L =
    {{(ACW-LEVEL_FRAC){1'b0}}, 1'b1, {(LEVEL_FRAC-1){1'b0}}};
  localparam logic signed [SW-1:0] S32_MAX = {{(SW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] S32_MIN = {{(SW-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] SMP_MAX = {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {{(SW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  // Filter state, entry index {stage, channel}.
  logic signed [STATE_BITS-1:0] in_hist_r [4];
  logic signed [STATE_BITS-1:0] out_hist_r [4];
  logic signed [STATE_BITS-1:0] lp_r [4];
  logic signed [STATE_BITS-1:0] bp_r [4];

  // Working registers.
  logic signed [STATE_BITS-1:0]  xin_r, low_r, high_r, nbp_r;
  logic signed [SAMPLE_BITS-1:0] right_smp_r, left_hold_r, out_left_r, out_right_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACW-1:0]         acc_r, acc_nxt;

  logic [1:0]                   idx;
  logic [3*CW-1:0]              shelf_sel, loop_sel;
  logic [2*CW-1:0]              taps_sel;
  logic signed [AW-1:0]         mul_a;
  logic signed [STATE_BITS-1:0] mul_b;
  logic signed [ACW-1:0]        rnd_c, rnd_l, rnd;
  logic signed [STATE_BITS-1:0] base, sub;
  logic                         neg;
  logic signed [SW-1:0]         sum;
  logic signed [STATE_BITS-1:0] res32;
  logic signed [SAMPLE_BITS-1:0] res_smp;

  assign idx = {ctl.stg, ctl.ch};

  // Operand selection for the shared multiplier.
  always_comb begin
    shelf_sel = shelf_coefs[ctl.stg];
    loop_sel  = band_loop[ctl.stg];
    taps_sel  = band_taps[ctl.stg];
    case (ctl.uw.a_sel)
      A_SH_B0: mul_a = AW'(signed'(shelf_sel[0 +: CW]));
      A_SH_B1: mul_a = AW'(signed'(shelf_sel[CW +: CW]));
      A_SH_A1: mul_a = AW'(signed'(shelf_sel[2*CW +: CW]));
      A_F:     mul_a = AW'(signed'(loop_sel[0 +: CW]));
      A_Q:     mul_a = AW'(signed'(loop_sel[CW +: CW]));
      A_F1:    mul_a = AW'(signed'(loop_sel[2*CW +: CW]));
      A_TD:    mul_a = AW'(signed'(taps_sel[0 +: CW]));
      A_TC:    mul_a = AW'(signed'(taps_sel[CW +: CW]));
      A_LEVEL: mul_a = AW'(level);
      default: mul_a = '0;
    endcase
    case (ctl.uw.b_sel)
      B_XIN:   mul_b = xin_r;
      B_INH:   mul_b = in_hist_r[idx];
      B_OUTH:  mul_b = out_hist_r[idx];
      B_BP:    mul_b = bp_r[idx];
      B_HIGH:  mul_b = high_r;
      B_NBP:   mul_b = nbp_r;
      default: mul_b = '0;
    endcase
  end

  // Accumulator update from the registered product.
  always_comb begin
    case (ctl.uw.acc_op)
      ACC_LOAD: acc_nxt = ACW'(prod_r);
      ACC_ADD:  acc_nxt = acc_r + ACW'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  // Round the accumulator, add the step's base terms and saturate.
  always_comb begin
    rnd_c = (acc_r + HALF_C) >>> FRAC;
    rnd_l = (acc_r + HALF_L) >>> LEVEL_FRAC;
    base  = '0;
    sub   = '0;
    neg   = 1'b0;
    case (ctl.uw.fin_op)
      FIN_LOW:  base = lp_r[idx];
      FIN_HIGH: begin
        base = xin_r;
        sub  = low_r;
        neg  = 1'b1;
      end
      FIN_NBP:  base = bp_r[idx];
      FIN_BAND: base = xin_r;
      default:  base = '0;
    endcase
    rnd = (ctl.uw.fin_op == FIN_LEVEL) ? rnd_l : rnd_c;
    sum = SW'(base) - SW'(sub) + (neg ? -SW'(rnd) : SW'(rnd));
    if (sum > S32_MAX) begin
      res32 = {1'b0, {(STATE_BITS-1){1'b1}}};
    end else if (sum < S32_MIN) begin
      res32 = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      res32 = sum[STATE_BITS-1:0];
    end
    if (sum > SMP_MAX) begin
      res_smp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (sum < SMP_MIN) begin
      res_smp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_smp = sum[SAMPLE_BITS-1:0];
    end
  end

  // Filter state: cleared by reset and by restart; a band register write clears that band's state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hist_r  <= '{default: '0};
      out_hist_r <= '{default: '0};
      lp_r       <= '{default: '0};
      bp_r       <= '{default: '0};
    end else if (ctl.start && in_restart) begin
      in_hist_r  <= '{default: '0};
      out_hist_r <= '{default: '0};
      lp_r       <= '{default: '0};
      bp_r       <= '{default: '0};
    end else begin
      if (band_clr[0]) begin
        lp_r[0] <= '0;
        lp_r[1] <= '0;
        bp_r[0] <= '0;
        bp_r[1] <= '0;
      end
      if (band_clr[1]) begin
        lp_r[2] <= '0;
        lp_r[3] <= '0;
        bp_r[2] <= '0;
        bp_r[3] <= '0;
      end
      case (ctl.uw.fin_op)
        FIN_SHELF: begin
          in_hist_r[idx]  <= xin_r;
          out_hist_r[idx] <= res32;
        end
        FIN_LOW:  lp_r[idx] <= res32;
        FIN_BAND: bp_r[idx] <= nbp_r;
        default: ;
      endcase
    end
  end

  // Multiplier, accumulator and working registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (ctl.start) begin
      xin_r       <= STATE_BITS'(in_left);
      right_smp_r <= in_right;
    end
    case (ctl.uw.fin_op)
      FIN_SHELF: xin_r  <= res32;
      FIN_LOW:   low_r  <= res32;
      FIN_HIGH:  high_r <= res32;
      FIN_NBP:   nbp_r  <= res32;
      FIN_BAND:  xin_r  <= res32;
      FIN_LEVEL: begin
        if (!ctl.ch) begin
          left_hold_r <= res_smp;
          xin_r       <= STATE_BITS'(right_smp_r);
        end
      end
      default: ;
    endcase
    if (ctl.emit) begin
      out_left_r  <= left_hold_r;
      out_right_r <= res_smp;
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

// ----- rtl/core/stereo_shelf_peak_equalizer_core.sv -----
// Top level of the stereo shelving and peaking equalizer.
// One transaction on the input channel carries a stereo frame; each channel goes
// through a low shelf, a high shelf, two state-variable peaking bands and the
// output level, and one result transaction carries the saturated pair. A single
// shared multiplier runs a 19-step microcode program per channel, and a band
// that is flat (both taps zero) is skipped. The block is ready for the next frame
// in the same cycle that the registered result is presented; a result that is
// not taken only stalls the block once the following frame is finished. The
// finished result sits in an output register while the next frame runs.
// Configuration writes are accepted every cycle and are meant for an idle block;
// a band register write clears that band's state, and the restart bit clears
// all state before its frame.
module stereo_shelf_peak_equalizer_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]        in_right_in,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_left_out,
  output logic signed [SAMPLE_BITS-1:0]        out_right_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sspeq_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [3*COEF_BITS-1:0]               cfg_wdata
);
  import sspeq_pkg::*;

  logic [3*COEF_BITS-1:0] shelf_coefs [2];
  logic [3*COEF_BITS-1:0] band_loop [2];
  logic [2*COEF_BITS-1:0] band_taps [2];
  logic [LEVEL_BITS-1:0]  level;
  logic [1:0]             band_clr;
  logic [1:0]             flat;
  seq_ctl_t               ctl;

  // Configuration registers.
  sspeq_cfg #(
    .COEF_BITS (COEF_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .shelf_coefs (shelf_coefs),
    .band_loop   (band_loop),
    .band_taps   (band_taps),
    .level       (level),
    .band_clr    (band_clr),
    .flat        (flat)
  );

  // Microcode sequencer and handshake.
  sspeq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flat      (flat),
    .ctl       (ctl)
  );

  // Arithmetic and filter state.
  sspeq_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_restart  (in_restart),
    .in_left     (in_left_in),
    .in_right    (in_right_in),
    .shelf_coefs (shelf_coefs),
    .band_loop   (band_loop),
    .band_taps   (band_taps),
    .level       (level),
    .band_clr    (band_clr),
    .out_left    (out_left_out),
    .out_right   (out_right_out)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the stereo shelf and peak equalizer core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sspeq_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W = 18;
  localparam int COEF_FRAC = COEF_W - 4;
  localparam int WORD_W = 3 * COEF_W;
  localparam int PHASES = 16;
  localparam int FRAMES_PER_PHASE = 100;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AFTER = 450;
  localparam int HOLD_CYCLES = 600;
  localparam reg_idx_t REG_UNUSED = 3'd7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  typedef enum logic { ROW_FRAME, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    sample_t   left;
    sample_t   right;
    logic      restart;
    logic      typed;
    sample_t   want_left;
    sample_t   want_right;
    reg_idx_t  idx;
    word_t     data;
  } plan_row_t;

  // Directed stimulus. Rows with typed set carry results that follow directly from
  // unity shelves, flat bands and a plain level gain; the rest use the predictor.
  localparam plan_row_t PLAN [32] = '{
    '{ROW_FRAME, 24'h000000, 24'h000000, 0, 1, 24'h000000, 24'h000000, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h7FFFFF, 24'h800000, 0, 1, 24'h7FFFFF, 24'h800000, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h800000, 24'h7FFFFF, 0, 1, 24'h800000, 24'h7FFFFF, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'hFFFFFF, 24'h000001, 0, 1, 24'hFFFFFF, 24'h000001, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h555555, 24'hAAAAAA, 1, 1, 24'h555555, 24'hAAAAAA, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_LEVEL, {42'h3FF_FFFF_FFFF, 12'hFFF}},
    '{ROW_FRAME, 24'h7FFFFF, 24'h800000, 0, 1, 24'h7FFFFF, 24'h800000, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h000001, 24'hFFFFFF, 0, 1, 24'h000008, 24'hFFFFF8, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_LEVEL, '0},
    '{ROW_FRAME, 24'h7FFFFF, 24'h123456, 0, 1, 24'h000000, 24'h000000, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_LEVEL, 54'd512},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_UNUSED, '1},
    '{ROW_FRAME, 24'h000003, 24'hFFFFFD, 0, 1, 24'h000003, 24'hFFFFFD, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_LOW_SHELF, {18'h02000, 18'h3F000, 18'h03000}},
    '{ROW_FRAME, 24'h400000, 24'hC00000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h100000, 24'h000000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_HIGH_SHELF, {18'h3E000, 18'h1FFFF, 18'h20000}},
    '{ROW_FRAME, 24'h7FFFFF, 24'h800000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_BAND1_LOOP, {18'h01000, 18'h04000, 18'h02000}},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_BAND1_TAPS, {18'h2AAAA, 18'h04000, 18'h3C000}},
    '{ROW_FRAME, 24'h200000, 24'hE00000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h200000, 24'hE00000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_BAND2_LOOP, {18'h1FFFF, 18'h20000, 18'h1FFFF}},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_BAND2_TAPS, {18'h15555, 18'h00000, 18'h00800}},
    '{ROW_FRAME, 24'h300000, 24'h000000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h000000, 24'h000000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_BAND1_TAPS, {18'h3FFFF, 18'h00000, 18'h00000}},
    '{ROW_FRAME, 24'h123456, 24'h654321, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h7FFFFF, 24'h7FFFFF, 1, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_WRITE, '0, '0, 0, 0, '0, '0, REG_LOW_SHELF, '1},
    '{ROW_FRAME, 24'h000000, 24'h000000, 0, 0, '0, '0, REG_LOW_SHELF, '0},
    '{ROW_FRAME, 24'h800000, 24'h800000, 0, 0, '0, '0, REG_LOW_SHELF, '0}
  };

  // Clock, reset and block inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_left_in = '0;
  sample_t in_right_in = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_left_out;
  sample_t out_right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = '0;
  word_t cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stereo_shelf_peak_equalizer_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .COEF_BITS  (COEF_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // Shadow copy of the registers and filter state of the block.
  word_t reg_shadow [7];
  int shelf_x1 [4];
  int shelf_y1 [4];
  int band_low [4];
  int band_bp [4];

  stereo_t equalized_q [$];
  int mismatches = 0;
  int frames_taken = 0;
  int burst_left = 1;
  bit steady = 1'b0;

  function automatic longint coef_at(word_t w, int slot);
    logic signed [COEF_W-1:0] c;
    c = w[slot*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  // Add half an LSB, then shift right with floor.
  function automatic longint round_off(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void clear_all();
    for (int k = 0; k < 4; k++) begin
      shelf_x1[k] = 0;
      shelf_y1[k] = 0;
      band_low[k] = 0;
      band_bp[k] = 0;
    end
  endfunction

  // First-order shelf: stage 0 is the low shelf, stage 1 the high shelf.
  function automatic int shelf_model(int stg, int ch, int x);
    word_t c;
    int i;
    longint acc;
    int y;
    c = reg_shadow[stg];
    i = stg * 2 + ch;
    acc = coef_at(c, 0) * x + coef_at(c, 1) * shelf_x1[i] + coef_at(c, 2) * shelf_y1[i];
    y = int'(saturate(round_off(acc, COEF_FRAC), STATE_BITS));
    shelf_x1[i] = x;
    shelf_y1[i] = y;
    return y;
  endfunction

  // State-variable peaking band; with both taps zero it passes the sample through.
  function automatic int band_model(int stg, int ch, int x);
    word_t loop_w;
    word_t taps_w;
    int i;
    longint f, q, f1, td, tc;
    int bp, low, high, nbp;
    loop_w = reg_shadow[REG_BAND1_LOOP + 2 * stg];
    taps_w = reg_shadow[REG_BAND1_TAPS + 2 * stg];
    i = stg * 2 + ch;
    f = coef_at(loop_w, 0);
    q = coef_at(loop_w, 1);
    f1 = coef_at(loop_w, 2);
    td = coef_at(taps_w, 0);
    tc = coef_at(taps_w, 1);
    if (td == 0 && tc == 0) return x;
    bp = band_bp[i];
    low = int'(saturate(longint'(band_low[i]) + round_off(f1 * bp, COEF_FRAC), STATE_BITS));
    high = int'(saturate(longint'(x) - low - round_off(q * bp, COEF_FRAC), STATE_BITS));
    nbp = int'(saturate(longint'(bp) + round_off(f * high, COEF_FRAC), STATE_BITS));
    band_low[i] = low;
    band_bp[i] = nbp;
    return int'(saturate(longint'(x) + round_off(td * bp + tc * nbp, COEF_FRAC), STATE_BITS));
  endfunction

  // Full equalizer chain for one stereo frame.
  function automatic stereo_t equalize_frame(sample_t l, sample_t r, logic rs);
    stereo_t res;
    int w;
    longint y;
    longint gain;
    res = '0;
    if (rs) clear_all();
    gain = longint'(reg_shadow[REG_LEVEL][LEVEL_BITS-1:0]);
    for (int ch = 0; ch < 2; ch++) begin
      w = (ch == 0) ? l : r;
      w = shelf_model(0, ch, w);
      w = shelf_model(1, ch, w);
      w = band_model(0, ch, w);
      w = band_model(1, ch, w);
      y = saturate(round_off(longint'(w) * gain, LEVEL_FRAC), SAMPLE_W);
      if (ch == 0) res.left = y[SAMPLE_W-1:0];
      else res.right = y[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Random coefficient: mostly within +/- span, sometimes extremes or raw bits.
  function automatic logic [COEF_W-1:0] pick_coef(int span);
    int v;
    logic [31:0] u;
    u = $urandom;
    v = int'($urandom_range(0, 2 * span)) - span;
    case ($urandom_range(0, 11))
      0: return {1'b0, {(COEF_W-1){1'b1}}};
      1: return {1'b1, {(COEF_W-1){1'b0}}};
      2: return '0;
      3: return u[COEF_W-1:0];
      default: return v[COEF_W-1:0];
    endcase
  endfunction

  function automatic sample_t pick_sample();
    int v;
    logic [31:0] u;
    u = $urandom;
    v = int'($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(0, 15))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      4, 5, 6: return v[SAMPLE_W-1:0];
      default: return u[SAMPLE_W-1:0];
    endcase
  endfunction

  // Offer one frame, record its predicted result, then maybe pause between bursts.
  task automatic next_frame(input sample_t l, input sample_t r, input logic rs,
                            input logic typed, input stereo_t given);
    stereo_t want;
    @(negedge clk);
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    want = equalize_frame(l, r, rs);
    equalized_q.push_back(typed ? given : want);
    frames_taken++;
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Stop offering frames and wait until every pending result has come out.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (equalized_q.size() != 0) @(posedge clk);
  endtask

  // One register write transaction, mirrored into the shadow copy.
  task automatic write_reg(input reg_idx_t idx, input word_t data);
    int stg;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOW_SHELF, REG_HIGH_SHELF, REG_BAND1_LOOP, REG_BAND2_LOOP:
        reg_shadow[idx] = data;
      REG_BAND1_TAPS, REG_BAND2_TAPS:
        reg_shadow[idx] = data & ((word_t'(1) << (2 * COEF_W)) - 1);
      REG_LEVEL:
        reg_shadow[idx] = data & ((word_t'(1) << LEVEL_BITS) - 1);
      default: ;
    endcase
    // Any band register write clears that band in both channels.
    if (idx >= REG_BAND1_LOOP && idx <= REG_BAND2_TAPS) begin
      stg = (idx >= REG_BAND2_LOOP) ? 1 : 0;
      for (int c = 0; c < 2; c++) begin
        band_low[stg * 2 + c] = 0;
        band_bp[stg * 2 + c] = 0;
      end
    end
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    stereo_t want;
    if (rst_n && out_valid && out_ready) begin
      if (equalized_q.size() == 0) begin
        $error("result with nothing pending: left_out %0d, right_out %0d",
               out_left_out, out_right_out);
        mismatches++;
      end else begin
        want = equalized_q.pop_front();
        if (out_left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, out_left_out);
          mismatches++;
        end
        if (out_right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, out_right_out);
          mismatches++;
        end
      end
    end
  end

  // Result side: short and long stalls, steady stretches, and one long hold-off
  // that lets the block fill up and back-pressure its input.
  initial begin : result_sink
    int up;
    int down;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && frames_taken >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk) out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      up = ($urandom_range(0, 4) == 0) ? 200 : int'($urandom_range(1, 12));
      down = ($urandom_range(0, 9) < 7) ? int'($urandom_range(1, 4))
                                         : int'($urandom_range(20, 90));
      @(negedge clk) out_ready <= 1'b1;
      repeat (up - 1) @(negedge clk);
      @(negedge clk) out_ready <= 1'b0;
      repeat (down - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] noise;
    word_t word;
    logic [LEVEL_BITS-1:0] lvl;
    reg_idx_t idx;

    // Register and state values after reset.
    foreach (reg_shadow[k]) reg_shadow[k] = '0;
    reg_shadow[REG_LOW_SHELF] = word_t'(1) << COEF_FRAC;
    reg_shadow[REG_HIGH_SHELF] = word_t'(1) << COEF_FRAC;
    reg_shadow[REG_LEVEL] = word_t'(LEVEL_RESET);
    clear_all();
    burst_left = $urandom_range(1, 12);

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed table.
    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        settle();
        write_reg(PLAN[r].idx, PLAN[r].data);
      end else begin
        next_frame(PLAN[r].left, PLAN[r].right, PLAN[r].restart, PLAN[r].typed,
                   {PLAN[r].want_left, PLAN[r].want_right});
      end
    end

    // Random phases. The first four use raw bits, all ones, all zeros and full gain;
    // later phases rewrite a random subset, so kept state carries across shelf and
    // level writes.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      for (int k = 0; k <= REG_UNUSED; k++) begin
        idx = reg_idx_t'(k);
        noise = {$urandom, $urandom};
        case (idx)
          REG_LOW_SHELF, REG_HIGH_SHELF:
            word = {pick_coef(14000), pick_coef(24000), pick_coef(24000)};
          REG_BAND1_LOOP, REG_BAND2_LOOP:
            word = {pick_coef(6000), pick_coef(20000), pick_coef(6000)};
          REG_BAND1_TAPS, REG_BAND2_TAPS:
            word = ($urandom_range(0, 2) == 0) ? {noise[WORD_W-1:36], 36'd0}
                 : {noise[WORD_W-1:36], pick_coef(16384), pick_coef(16384)};
          REG_LEVEL: begin
            case ($urandom_range(0, 3))
              0: lvl = '0;
              1: lvl = '1;
              2: lvl = LEVEL_RESET;
              default: lvl = LEVEL_BITS'($urandom_range(128, 1024));
            endcase
            word = {noise[WORD_W-1:LEVEL_BITS], lvl};
          end
          default: word = noise[WORD_W-1:0];
        endcase
        if (p == 0) word = noise[WORD_W-1:0];
        else if (p == 1) word = '1;
        else if (p == 2) word = '0;
        else if (p == 3 && idx == REG_LEVEL) word[LEVEL_BITS-1:0] = '1;
        if (p < 4 || $urandom_range(0, 2) != 0) write_reg(idx, word);
      end
      steady = (p % 4 == 2);
      repeat (FRAMES_PER_PHASE)
        next_frame(pick_sample(), pick_sample(), $urandom_range(0, 31) == 0, 1'b0, '0);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sspeq_pkg.sv
rtl/core/sspeq_cfg.sv
rtl/core/sspeq_seq.sv
rtl/core/sspeq_dpath.sv
rtl/core/stereo_shelf_peak_equalizer_core.sv
verif/testbench.sv
